// File: rtl/ppm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppm_pkg;

	localparam int IDX_W      = 12;
	localparam int COL_W      = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 12;

	// datapath widths
	localparam int PA_W = 24;	// 2500 * i
	localparam int PB_W = 21;	// 490 * i
	localparam int SQ_W = 24;	// i * i
	localparam int PQ_W = 38;	// 9667 * i * i
	localparam int Q1_W = 26;	// quotient width of the first divider
	localparam int T_W  = 27;	// floor(quadratic / n)
	localparam int D2_W = 16;	// 10 * n
	localparam int Q2_W = 8;	// terrain green
	localparam int QA_W = 12;
	localparam int QB_W = 9;

	typedef enum logic [1:0] {
		MODE_GREY    = 2'd0,
		MODE_HEAT    = 2'd1,
		MODE_CYMG    = 2'd2,
		MODE_TERRAIN = 2'd3
	} palette_mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_MODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = 8'd1;
	localparam logic [IDX_W-1:0]     LEVEL_COUNT_RST  = 12'd256;

	// slope constants, scaled by 10 where the formula has a decimal
	localparam logic [11:0] K_HEAT    = 12'd2500;
	localparam logic [11:0] K_CYMG    = 12'd240;
	localparam logic [11:0] K_TR_RLO  = 12'd450;
	localparam logic [11:0] K_TR_RHI  = 12'd40;
	localparam logic [8:0]  K_TR_GLO  = 9'd130;
	localparam logic [8:0]  K_TR_BHI  = 9'd490;
	localparam logic [13:0] C_SQ      = 14'd9667;
	localparam logic [12:0] C_N       = 13'd6883;
	localparam logic [13:0] C_I       = 14'd14100;
	localparam logic [11:0] HEAT_B_OFS = 12'd2245;
	// floor(q/7) == (q * 2341) >> 14 for q < 4096
	localparam logic [11:0] RECIP7    = 12'd2341;
	localparam int          RECIP7_SH = 14;

	typedef struct packed {
		logic                 valid;
		logic                 ok;
		logic                 zero;
		logic                 low;
		palette_mode_t        mode;
		logic [IDX_W-1:0]     n;
		logic [IDX_W-1:0]     i;
		logic [COL_W-1:0]     grey;
	} side_t;

	typedef struct packed {
		logic                 valid;
		logic                 ok;
		logic                 zero;
		logic                 low;
		palette_mode_t        mode;
		logic [QA_W-1:0]      qa;
		logic                 rem_nz;
		logic [QB_W-1:0]      qb;
		logic [COL_W-1:0]     grey;
	} tail_t;

	typedef struct packed {
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
		logic             in_range;
	} out_item_t;

endpackage
`default_nettype wire

// File: rtl/ppm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ppm_in_if;
	logic                        valid;
	logic                        ready;
	logic [ppm_pkg::IDX_W-1:0]   entry_index;
	modport source (output valid, output entry_index, input ready);
	modport sink   (input valid, input entry_index, output ready);
endinterface
`default_nettype wire

// File: rtl/ppm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ppm_out_if;
	logic                        valid;
	logic                        ready;
	logic [ppm_pkg::COL_W-1:0]   red;
	logic [ppm_pkg::COL_W-1:0]   green;
	logic [ppm_pkg::COL_W-1:0]   blue;
	logic                        in_range;
	modport source (output valid, output red, output green, output blue, output in_range,
		input ready);
	modport sink   (input valid, input red, input green, input blue, input in_range,
		output ready);
endinterface
`default_nettype wire

// File: rtl/ppm_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ppm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ppm_pkg::CFG_IDX_W-1:0]    index;
	logic [ppm_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/ppm_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage. Needs num < den * 2**QW.
module ppm_div_pipe #(
	parameter int NW = 24,
	parameter int DW = 12,
	parameter int QW = 26
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic [NW-1:0] rem
);

	localparam int XW = NW + DW + QW;

	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	logic [NW-1:0] rem_in [QW];
	logic [DW-1:0] den_in [QW];
	logic [QW-1:0] quo_in [QW];
	logic [XW-1:0] trial  [QW];
	logic          take   [QW];

	always_comb begin
		rem_in[0] = num;
		den_in[0] = den;
		quo_in[0] = '0;
		for (int k = 1; k < QW; k++) begin
			rem_in[k] = rem_s[k-1];
			den_in[k] = den_s[k-1];
			quo_in[k] = quo_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			trial[k] = XW'(den_in[k]) << (QW - 1 - k);
			take[k]  = XW'(rem_in[k]) >= trial[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k] <= take[k] ? NW'(XW'(rem_in[k]) - trial[k]) : rem_in[k];
				den_s[k] <= den_in[k];
				quo_s[k] <= quo_in[k] | (QW'(take[k]) << (QW - 1 - k));
			end
		end
	end

	assign quo = quo_s[QW-1];
	assign rem = rem_s[QW-1];

endmodule
`default_nettype wire

// File: rtl/pseudocolor_palette_map.sv
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid / ready | entry_index[11:0]
//  out_ch   | out | valid / ready | red[7:0] green[7:0] blue[7:0] in_range
//  cfg_ch   | in  | valid / ready | index[7:0] data[11:0]; ready is always high
//
//  One transfer per cycle in while the output queue has room, and out while out_ch.ready is high.
//  Results pass the 26-stage dividers by n, then the 8-stage divider by 10n, into the queue.
//  arst_n clears the registers to grey mode, 256 levels, and empties the pipeline.
//  The pipeline advances as one while the 2-entry output queue has room, so a result
//  waiting on out_ch does not block input until the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module pseudocolor_palette_map #(
	parameter int MAX_LEVELS = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	ppm_in_if.sink      in_ch,
	ppm_out_if.source   out_ch,
	ppm_cfg_if.sink     cfg_ch
);

	localparam int LIM_W    = 17;
	localparam int DIV1_LAT = ppm_pkg::Q1_W;
	localparam int DIV2_LAT = ppm_pkg::Q2_W;

	// ---------------- configuration registers ----------------
	ppm_pkg::palette_mode_t          mode_q;
	logic [ppm_pkg::IDX_W-1:0]       level_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ppm_pkg::MODE_GREY;
			level_q <= ppm_pkg::LEVEL_COUNT_RST;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.index == ppm_pkg::REG_PALETTE_MODE) begin
				mode_q <= ppm_pkg::palette_mode_t'(cfg_ch.data[1:0]);
			end else if (cfg_ch.index == ppm_pkg::REG_LEVEL_COUNT) begin
				level_q <= cfg_ch.data;
			end
		end
	end

	// ---------------- global advance ----------------
	logic [1:0] count_q;
	logic       en;
	assign en          = (count_q != 2'd2);
	assign in_ch.ready = en;

	// ---------------- stage 1: capture ----------------
	logic                      valid_s1;
	logic [ppm_pkg::IDX_W-1:0] e_s1;
	logic [ppm_pkg::IDX_W-1:0] n_s1;
	ppm_pkg::palette_mode_t    mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1    <= in_ch.entry_index;
			n_s1    <= level_q;
			mode_s1 <= mode_q;
		end
	end

	// ---------------- stage 2: range check, slopes ----------------
	logic                      lim_ok;
	logic                      ok_c;
	logic                      low_c;
	logic [ppm_pkg::IDX_W-1:0] i_c;
	logic [11:0]               ka_c;
	logic [8:0]                kb_c;
	ppm_pkg::side_t            side_c;

	always_comb begin
		lim_ok = LIM_W'(e_s1) < LIM_W'(MAX_LEVELS);
		i_c    = e_s1 - 12'd1;
		low_c  = (13'(i_c) << 1) < 13'(n_s1);
		if (mode_s1 == ppm_pkg::MODE_GREY) begin
			ok_c = lim_ok && (e_s1 < n_s1);
		end else begin
			ok_c = lim_ok && (e_s1 <= n_s1);
		end
		ka_c = '0;
		kb_c = '0;
		case (mode_s1)
			ppm_pkg::MODE_HEAT: ka_c = ppm_pkg::K_HEAT;
			ppm_pkg::MODE_CYMG: ka_c = ppm_pkg::K_CYMG;
			ppm_pkg::MODE_TERRAIN: begin
				ka_c = low_c ? ppm_pkg::K_TR_RLO : ppm_pkg::K_TR_RHI;
				kb_c = low_c ? ppm_pkg::K_TR_GLO : ppm_pkg::K_TR_BHI;
			end
			default: begin
				ka_c = '0;
				kb_c = '0;
			end
		endcase
		side_c.valid = valid_s1;
		side_c.ok    = ok_c;
		side_c.zero  = (e_s1 == '0);
		side_c.low   = low_c;
		side_c.mode  = mode_s1;
		side_c.n     = n_s1;
		side_c.i     = i_c;
		side_c.grey  = e_s1[ppm_pkg::COL_W-1:0];
	end

	ppm_pkg::side_t              side_s2;
	logic [ppm_pkg::PA_W-1:0]    pa_s2;
	logic [ppm_pkg::PB_W-1:0]    pb_s2;
	logic [ppm_pkg::SQ_W-1:0]    sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (en) begin
			side_s2 <= side_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2 <= ppm_pkg::PA_W'(i_c) * ppm_pkg::PA_W'(ka_c);
			pb_s2 <= ppm_pkg::PB_W'(i_c) * ppm_pkg::PB_W'(kb_c);
			sq_s2 <= ppm_pkg::SQ_W'(i_c) * ppm_pkg::SQ_W'(i_c);
		end
	end

	// ---------------- stage 3: 9667 * i^2 ----------------
	ppm_pkg::side_t              side_s3;
	logic [ppm_pkg::PA_W-1:0]    pa_s3;
	logic [ppm_pkg::PB_W-1:0]    pb_s3;
	logic [ppm_pkg::PQ_W-1:0]    pq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (en) begin
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s3 <= pa_s2;
			pb_s3 <= pb_s2;
			pq_s3 <= ppm_pkg::PQ_W'(sq_s2) * ppm_pkg::PQ_W'(ppm_pkg::C_SQ);
		end
	end

	// ---------------- first divider bank: all by n ----------------
	logic [ppm_pkg::Q1_W-1:0] qa_full, qb_full, q1;
	logic [ppm_pkg::PA_W-1:0] ra;
	logic [ppm_pkg::PB_W-1:0] rb_unused_w;
	logic [ppm_pkg::PQ_W-1:0] r1_unused_w;

	ppm_div_pipe #(.NW(ppm_pkg::PA_W), .DW(ppm_pkg::IDX_W), .QW(DIV1_LAT)) u_div_a (
		.clk(clk), .en(en), .num(pa_s3), .den(side_s3.n), .quo(qa_full), .rem(ra)
	);
	ppm_div_pipe #(.NW(ppm_pkg::PB_W), .DW(ppm_pkg::IDX_W), .QW(DIV1_LAT)) u_div_b (
		.clk(clk), .en(en), .num(pb_s3), .den(side_s3.n), .quo(qb_full), .rem(rb_unused_w)
	);
	ppm_div_pipe #(.NW(ppm_pkg::PQ_W), .DW(ppm_pkg::IDX_W), .QW(DIV1_LAT)) u_div_q (
		.clk(clk), .en(en), .num(pq_s3), .den(side_s3.n), .quo(q1), .rem(r1_unused_w)
	);

	ppm_pkg::side_t side_d1_s [DIV1_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV1_LAT; k++) side_d1_s[k] <= '0;
		end else if (en) begin
			side_d1_s[0] <= side_s3;
			for (int k = 1; k < DIV1_LAT; k++) side_d1_s[k] <= side_d1_s[k-1];
		end
	end

	// ---------------- stage 4: floor(quadratic / n) ----------------
	ppm_pkg::side_t            sd1;
	ppm_pkg::tail_t            tail_c;
	logic [ppm_pkg::T_W-1:0]   t_c;

	always_comb begin
		sd1 = side_d1_s[DIV1_LAT-1];
		t_c = ppm_pkg::T_W'(sd1.n) * ppm_pkg::T_W'(ppm_pkg::C_N)
			+ ppm_pkg::T_W'(q1)
			- ppm_pkg::T_W'(sd1.i) * ppm_pkg::T_W'(ppm_pkg::C_I);
		tail_c.valid  = sd1.valid;
		tail_c.ok     = sd1.ok;
		tail_c.zero   = sd1.zero;
		tail_c.low    = sd1.low;
		tail_c.mode   = sd1.mode;
		tail_c.qa     = qa_full[ppm_pkg::QA_W-1:0];
		tail_c.rem_nz = (ra != '0);
		tail_c.qb     = qb_full[ppm_pkg::QB_W-1:0];
		tail_c.grey   = sd1.grey;
	end

	ppm_pkg::tail_t            tail_s4;
	logic [ppm_pkg::T_W-1:0]   t_s4;
	logic [ppm_pkg::D2_W-1:0]  d2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_s4 <= '0;
		end else if (en) begin
			tail_s4 <= tail_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4  <= t_c;
			d2_s4 <= ppm_pkg::D2_W'(sd1.n) * ppm_pkg::D2_W'(10);
		end
	end

	// ---------------- second divider: terrain green = T / (10 n) ----------------
	logic [ppm_pkg::Q2_W-1:0] q2;
	logic [ppm_pkg::T_W-1:0]  r2_unused_w;

	ppm_div_pipe #(.NW(ppm_pkg::T_W), .DW(ppm_pkg::D2_W), .QW(DIV2_LAT)) u_div_g (
		.clk(clk), .en(en), .num(t_s4), .den(d2_s4), .quo(q2), .rem(r2_unused_w)
	);

	ppm_pkg::tail_t tail_d2_s [DIV2_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV2_LAT; k++) tail_d2_s[k] <= '0;
		end else if (en) begin
			tail_d2_s[0] <= tail_s4;
			for (int k = 1; k < DIV2_LAT; k++) tail_d2_s[k] <= tail_d2_s[k-1];
		end
	end

	// ---------------- color assembly ----------------
	ppm_pkg::tail_t     tl;
	ppm_pkg::out_item_t res_c;
	logic [23:0]        g7_prod;
	logic [9:0]         g7;
	logic [9:0]         cm_g;

	always_comb begin
		tl      = tail_d2_s[DIV2_LAT-1];
		g7_prod = 24'(tl.qa) * 24'(ppm_pkg::RECIP7);
		g7      = g7_prod[ppm_pkg::RECIP7_SH +: 10];
		cm_g    = 10'd365 - 10'(tl.qa) - 10'(tl.rem_nz);
		res_c.red      = '0;
		res_c.green    = '0;
		res_c.blue     = '0;
		res_c.in_range = tl.ok;
		if (!tl.ok) begin
			res_c.in_range = 1'b0;
		end else if (tl.mode == ppm_pkg::MODE_GREY) begin
			res_c.red   = tl.grey;
			res_c.green = tl.grey;
			res_c.blue  = tl.grey;
		end else if (tl.zero) begin
			// background entry
			res_c.red   = 8'd255;
			res_c.green = 8'd255;
			res_c.blue  = 8'd255;
		end else begin
			case (tl.mode)
				ppm_pkg::MODE_HEAT: begin
					res_c.red   = 8'd255;
					res_c.green = (g7 > 10'd255) ? 8'd255 : g7[7:0];
					res_c.blue  = (tl.qa >= ppm_pkg::HEAT_B_OFS)
						? 8'(tl.qa - ppm_pkg::HEAT_B_OFS) : 8'd0;
				end
				ppm_pkg::MODE_CYMG: begin
					res_c.red   = tl.low ? 8'(12'd125 + tl.qa) : 8'd245;
					res_c.green = tl.low ? 8'd245 : cm_g[7:0];
					res_c.blue  = 8'd245;
				end
				ppm_pkg::MODE_TERRAIN: begin
					if (tl.low) begin
						res_c.red   = tl.qa[7:0];
						res_c.green = 8'(9'd160 + tl.qb);
						res_c.blue  = 8'd0;
					end else begin
						res_c.red   = 8'(12'd205 + tl.qa);
						res_c.green = q2;
						res_c.blue  = 8'(tl.qb - 9'd245);
					end
				end
				default: begin
					res_c.red   = '0;
					res_c.green = '0;
					res_c.blue  = '0;
				end
			endcase
		end
	end

	// ---------------- 2-entry output queue ----------------
	ppm_pkg::out_item_t mem_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic               push, pop;

	assign push = en && tl.valid;
	assign pop  = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= res_c;
	end

	assign out_ch.valid    = (count_q != 2'd0);
	assign out_ch.red      = mem_q[rd_ptr_q].red;
	assign out_ch.green    = mem_q[rd_ptr_q].green;
	assign out_ch.blue     = mem_q[rd_ptr_q].blue;
	assign out_ch.in_range = mem_q[rd_ptr_q].in_range;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("output queue overflow");
	a_black_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.in_range) |->
		(out_ch.red == 8'd0 && out_ch.green == 8'd0 && out_ch.blue == 8'd0))
		else $error("out of range entry not black");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(side_d1_s[DIV1_LAT-1]) && $stable(tail_s4))
		else $error("pipeline moved while stalled");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count not incremented");
`endif

endmodule
`default_nettype wire
